/* src/lru_k_page_replacer_defines.svh */
// ----------------------------------------------------------------------------
// lru_k_page_replacer_defines.svh
// Assertion macros for the LRU-K page replacer.
// ----------------------------------------------------------------------------
`ifndef LRU_K_PAGE_REPLACER_DEFINES_SVH
`define LRU_K_PAGE_REPLACER_DEFINES_SVH

// condition holds on every clock edge out of reset
`define LRK_ASSERT_ALWAYS(lbl, cond, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (cond)) else $error(msg);

// antecedent implies consequent in the same cycle
`define LRK_ASSERT_IMPLY(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// antecedent implies consequent in the next cycle
`define LRK_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

/* src/lrk_pkg.sv */
// ----------------------------------------------------------------------------
// lrk_pkg
// Shared types and constants of the LRU-K page replacer.
// ----------------------------------------------------------------------------
`default_nettype none

package lrk_pkg;

  localparam int FRAMES_DEF = 16;
  localparam int K_MAX_DEF  = 8;

  localparam int ACT_W     = 2;
  localparam int FRAME_IO_W = 4;
  localparam int COUNT_W   = 5;
  localparam int STAMP_W   = 32;
  localparam int K_W       = 4;

  localparam logic [K_W-1:0] K_RESET = 4'd2;

  typedef enum logic [ACT_W-1:0] {
    ACT_RECORD = 2'd0,
    ACT_MARK   = 2'd1,
    ACT_REMOVE = 2'd2,
    ACT_EVICT  = 2'd3
  } action_t;

  typedef struct packed {
    logic clear;
    logic en;
    logic inf;
  } scan_ctl_t;

endpackage

`default_nettype wire

/* src/lrk_if.sv */
// ----------------------------------------------------------------------------
// lrk_if
// Request and response channels of the LRU-K page replacer.
// ----------------------------------------------------------------------------
`default_nettype none

interface lrk_req_if;
  import lrk_pkg::*;

  logic               valid;
  logic               ready;
  logic [ACT_W-1:0]   action;
  logic [FRAME_IO_W-1:0] frame;
  logic               evictable_flag;

  modport source (output valid, output action, output frame, output evictable_flag,
                  input ready);
  modport sink   (input valid, input action, input frame, input evictable_flag,
                  output ready);
endinterface

interface lrk_rsp_if;
  import lrk_pkg::*;

  logic                  valid;
  logic                  ready;
  logic                  status;
  logic [FRAME_IO_W-1:0] victim_frame;
  logic [COUNT_W-1:0]    evictable_count;

  modport source (output valid, output status, output victim_frame,
                  output evictable_count, input ready);
  modport sink   (input valid, input status, input victim_frame,
                  input evictable_count, output ready);
endinterface

`default_nettype wire

/* src/lru_k_page_replacer.sv */
// ----------------------------------------------------------------------------
// lru_k_page_replacer
// LRU-K victim selection over a pool of buffer frames.
//
//   channel  dir  handshake     payload
//   req      in   valid/ready   action, frame, evictable_flag
//   rsp      out  valid/ready   status, victim_frame, evictable_count
//   cfg      in   cfg_we        cfg_wdata (k)
//
// Record, mark and remove pass from accept through the EXEC state to the output register.
// Evict scans one frame a cycle through the stamp RAM
// read port into the single age comparator, then the update.
// Reset clears all frame state at once; the stamp RAM is not cleared.
// A result waits in the output register; the next item is accepted
// meanwhile and completes once that register is free.
// ----------------------------------------------------------------------------
`default_nettype none

`include "lru_k_page_replacer_defines.svh"

module lru_k_page_replacer #(
  parameter int FRAMES = lrk_pkg::FRAMES_DEF,
  parameter int K_MAX  = lrk_pkg::K_MAX_DEF
) (
  input  wire logic                   clk,
  input  wire logic                   rst,
  lrk_req_if.sink                     req,
  lrk_rsp_if.source                   rsp,
  input  wire logic                   cfg_we,
  input  wire logic [lrk_pkg::K_W-1:0] cfg_wdata
);
  import lrk_pkg::*;

  localparam int FRAME_W = $clog2(FRAMES);
  localparam int CNT_W   = $clog2(K_MAX + 1);
  localparam int HEAD_W  = (K_MAX > 1) ? $clog2(K_MAX) : 1;
  localparam int SLOT_W  = CNT_W + 1;
  localparam int DEPTH   = FRAMES * K_MAX;
  localparam int ADDR_W  = $clog2(DEPTH);
  localparam int SCAN_W  = $clog2(FRAMES + 1);

  typedef enum logic [3:0] {
    S_IDLE  = 4'b0001,
    S_EXEC  = 4'b0010,
    S_SCAN  = 4'b0100,
    S_EVICT = 4'b1000
  } state_t;

  state_t state, state_next;

  action_t               act_r;
  logic [FRAME_IO_W-1:0] frame_r;
  logic                  flag_r;
  logic [K_W-1:0]        k_reg;
  logic [STAMP_W-1:0]    now_stamp;

  logic [FRAMES-1:0]     tracked;
  logic [FRAMES-1:0]     evict_mark;
  logic [CNT_W-1:0]      acc_cnt [FRAMES];
  logic [HEAD_W-1:0]     head [FRAMES];
  logic [COUNT_W-1:0]    ev_total;

  logic [SCAN_W-1:0]     scan_idx;
  logic                  p_v;
  logic                  p_inf;
  logic [FRAME_W-1:0]    p_idx;

  logic                  rsp_valid;
  logic                  rsp_status;
  logic [FRAME_IO_W-1:0] rsp_victim;
  logic [COUNT_W-1:0]    rsp_count;

  logic                  accept;
  logic                  out_free;
  logic                  commit;
  logic                  in_range;
  logic                  issue;
  logic [CNT_W-1:0]      k_eff;
  logic [FRAME_W-1:0]    fidx;
  logic [FRAME_W-1:0]    meta_idx;
  logic                  m_trk;
  logic                  m_ev;
  logic [CNT_W-1:0]      m_cnt;
  logic [HEAD_W-1:0]     m_head;
  logic                  m_inf;
  logic [CNT_W-1:0]      back_n;
  logic [SLOT_W-1:0]     slot_sum;
  logic [SLOT_W-1:0]     slot_mod;
  logic [ADDR_W-1:0]     rd_addr;
  logic [ADDR_W-1:0]     wr_addr;
  logic [CNT_W-1:0]      base_cnt;
  logic [HEAD_W-1:0]     base_head;
  logic [CNT_W-1:0]      head_sum;
  logic [HEAD_W-1:0]     head_next;
  logic [CNT_W-1:0]      cnt_next;
  logic [COUNT_W-1:0]    total_dec;

  logic                  tw_en;
  logic [FRAME_W-1:0]    tw_idx;
  logic                  tw_trk;
  logic                  tw_ev;
  logic [CNT_W-1:0]      tw_cnt;
  logic [HEAD_W-1:0]     tw_head;
  logic                  mem_we;
  logic                  now_inc;
  logic                  res_status;
  logic [FRAME_IO_W-1:0] res_victim;
  logic [COUNT_W-1:0]    total_next;

  logic [STAMP_W-1:0]    rd_stamp;
  scan_ctl_t             cmp_ctl;
  logic                  best_found;
  logic [FRAME_W-1:0]    best_idx;

  assign accept   = req.valid && req.ready;
  assign out_free = !rsp_valid || rsp.ready;
  assign commit   = out_free && ((state == S_EXEC) || (state == S_EVICT));
  assign in_range = 32'(frame_r) < FRAMES;
  assign fidx     = FRAME_W'(frame_r);
  assign issue    = (state == S_SCAN) && (32'(scan_idx) < FRAMES);

  always_comb begin
    if (k_reg == '0) begin
      k_eff = CNT_W'(1);
    end else if (32'(k_reg) > K_MAX) begin
      k_eff = CNT_W'(K_MAX);
    end else begin
      k_eff = CNT_W'(k_reg);
    end
  end

  // one frame-table read port, shared by scan and single-frame actions
  assign meta_idx = (state == S_SCAN) ? scan_idx[FRAME_W-1:0] : fidx;
  assign m_trk    = tracked[meta_idx];
  assign m_ev     = evict_mark[meta_idx];
  assign m_cnt    = acc_cnt[meta_idx];
  assign m_head   = head[meta_idx];
  assign m_inf    = m_cnt < k_eff;
  assign back_n   = m_inf ? m_cnt : k_eff;

  // slot written back_n accesses ago
  assign slot_sum = SLOT_W'(m_head) + SLOT_W'(K_MAX) - SLOT_W'(back_n);
  assign slot_mod = (slot_sum >= SLOT_W'(K_MAX)) ? slot_sum - SLOT_W'(K_MAX) : slot_sum;
  assign rd_addr  = ADDR_W'(meta_idx) * ADDR_W'(K_MAX) + ADDR_W'(HEAD_W'(slot_mod));

  assign base_cnt  = m_trk ? m_cnt : '0;
  assign base_head = m_trk ? m_head : '0;
  assign wr_addr   = ADDR_W'(fidx) * ADDR_W'(K_MAX) + ADDR_W'(base_head);
  assign head_sum  = CNT_W'(base_head) + CNT_W'(1);
  assign head_next = (head_sum == CNT_W'(K_MAX)) ? '0 : HEAD_W'(head_sum);
  assign cnt_next  = (base_cnt < CNT_W'(K_MAX)) ? base_cnt + CNT_W'(1) : base_cnt;
  assign total_dec = (ev_total != '0) ? ev_total - COUNT_W'(1) : ev_total;

  always_comb begin
    tw_en      = 1'b0;
    tw_idx     = fidx;
    tw_trk     = 1'b0;
    tw_ev      = 1'b0;
    tw_cnt     = '0;
    tw_head    = '0;
    mem_we     = 1'b0;
    now_inc    = 1'b0;
    res_status = 1'b1;
    res_victim = '0;
    total_next = ev_total;
    if (state == S_EXEC) begin
      unique case (act_r)
        ACT_RECORD: begin
          if (in_range) begin
            tw_en      = 1'b1;
            tw_trk     = 1'b1;
            tw_ev      = m_trk && m_ev;
            tw_cnt     = cnt_next;
            tw_head    = head_next;
            mem_we     = 1'b1;
            now_inc    = 1'b1;
            res_status = 1'b0;
          end
        end
        ACT_MARK: begin
          if (in_range && m_trk && (m_ev != flag_r)) begin
            tw_en      = 1'b1;
            tw_trk     = 1'b1;
            tw_ev      = flag_r;
            tw_cnt     = m_cnt;
            tw_head    = m_head;
            total_next = flag_r ? ev_total + COUNT_W'(1) : total_dec;
            res_status = 1'b0;
          end
        end
        ACT_REMOVE: begin
          if (in_range && m_trk && m_ev) begin
            tw_en      = 1'b1;
            total_next = total_dec;
            res_status = 1'b0;
          end
        end
        ACT_EVICT: begin
        end
      endcase
    end else if (state == S_EVICT) begin
      if (best_found) begin
        tw_en      = 1'b1;
        tw_idx     = best_idx;
        total_next = total_dec;
        res_status = 1'b0;
        res_victim = FRAME_IO_W'(best_idx);
      end
    end
  end

  always_comb begin
    state_next = state;
    unique case (state)
      S_IDLE: begin
        if (accept) begin
          state_next = (action_t'(req.action) == ACT_EVICT) ? S_SCAN : S_EXEC;
        end
      end
      S_EXEC: begin
        if (out_free) begin
          state_next = S_IDLE;
        end
      end
      S_SCAN: begin
        if (scan_idx == SCAN_W'(FRAMES)) begin
          state_next = S_EVICT;
        end
      end
      S_EVICT: begin
        if (out_free) begin
          state_next = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      k_reg     <= K_RESET;
      now_stamp <= '0;
      ev_total  <= '0;
      p_v       <= 1'b0;
      rsp_valid <= 1'b0;
    end else begin
      state <= state_next;
      if (cfg_we) begin
        k_reg <= cfg_wdata;
      end
      if (commit && now_inc) begin
        now_stamp <= now_stamp + STAMP_W'(1);
      end
      if (commit) begin
        ev_total <= total_next;
      end
      p_v <= issue && m_trk && m_ev;
      if (commit) begin
        rsp_valid <= 1'b1;
      end else if (rsp.ready) begin
        rsp_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      act_r   <= action_t'(req.action);
      frame_r <= req.frame;
      flag_r  <= req.evictable_flag;
    end
    if (accept) begin
      scan_idx <= '0;
    end else if (state == S_SCAN) begin
      scan_idx <= scan_idx + SCAN_W'(1);
    end
    p_inf <= m_inf;
    p_idx <= meta_idx;
    if (commit) begin
      rsp_status <= res_status;
      rsp_victim <= res_victim;
      rsp_count  <= total_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      tracked    <= '0;
      evict_mark <= '0;
      for (int i = 0; i < FRAMES; i++) begin
        acc_cnt[i] <= '0;
        head[i]    <= '0;
      end
    end else if (commit && tw_en) begin
      tracked[tw_idx]    <= tw_trk;
      evict_mark[tw_idx] <= tw_ev;
      acc_cnt[tw_idx]    <= tw_cnt;
      head[tw_idx]       <= tw_head;
    end
  end

  lrk_stamp_ram #(
    .DEPTH  (DEPTH),
    .ADDR_W (ADDR_W)
  ) u_ram (
    .clk   (clk),
    .we    (commit && mem_we),
    .waddr (wr_addr),
    .wdata (now_stamp),
    .raddr (rd_addr),
    .rdata (rd_stamp)
  );

  assign cmp_ctl.clear = accept && (action_t'(req.action) == ACT_EVICT);
  assign cmp_ctl.en    = p_v;
  assign cmp_ctl.inf   = p_inf;

  lrk_victim_cmp #(
    .IDX_W (FRAME_W)
  ) u_cmp (
    .clk      (clk),
    .rst      (rst),
    .ctl      (cmp_ctl),
    .now      (now_stamp),
    .stamp    (rd_stamp),
    .idx      (p_idx),
    .found    (best_found),
    .best_idx (best_idx)
  );

  assign req.ready           = (state == S_IDLE);
  assign rsp.valid           = rsp_valid;
  assign rsp.status          = rsp_status;
  assign rsp.victim_frame    = rsp_victim;
  assign rsp.evictable_count = rsp_count;

  `LRK_ASSERT_ALWAYS(a_total_matches, $countones(evict_mark) == int'(ev_total), "evictable total out of step with marks")
  `LRK_ASSERT_ALWAYS(a_ev_tracked, (evict_mark & ~tracked) == '0, "evictable mark on untracked frame")
  `LRK_ASSERT_IMPLY(a_victim_ok, (state == S_EVICT) && out_free && best_found, tracked[best_idx] && evict_mark[best_idx], "victim not an evictable frame")
  `LRK_ASSERT_NEXT(a_busy, accept, !req.ready, "item accepted while busy")

endmodule

`default_nettype wire

/* src/lrk_stamp_ram.sv */
// ----------------------------------------------------------------------------
// lrk_stamp_ram
// Stamp history store: one write port, one registered read port.
// ----------------------------------------------------------------------------
`default_nettype none

module lrk_stamp_ram #(
  parameter int DEPTH  = 128,
  parameter int ADDR_W = 7
) (
  input  wire logic                        clk,
  input  wire logic                        we,
  input  wire logic [ADDR_W-1:0]           waddr,
  input  wire logic [lrk_pkg::STAMP_W-1:0] wdata,
  input  wire logic [ADDR_W-1:0]           raddr,
  output logic      [lrk_pkg::STAMP_W-1:0] rdata
);
  import lrk_pkg::*;

  logic [STAMP_W-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

`default_nettype wire

/* src/lrk_victim_cmp.sv */
// ----------------------------------------------------------------------------
// lrk_victim_cmp
// Shared age comparator; keeps the best candidate seen during a scan.
// ----------------------------------------------------------------------------
`default_nettype none

module lrk_victim_cmp #(
  parameter int IDX_W = 4
) (
  input  wire logic                        clk,
  input  wire logic                        rst,
  input  wire lrk_pkg::scan_ctl_t          ctl,
  input  wire logic [lrk_pkg::STAMP_W-1:0] now,
  input  wire logic [lrk_pkg::STAMP_W-1:0] stamp,
  input  wire logic [IDX_W-1:0]            idx,
  output logic                             found,
  output logic      [IDX_W-1:0]            best_idx
);
  import lrk_pkg::*;

  logic [STAMP_W-1:0] age;
  logic [STAMP_W-1:0] best_age;
  logic               best_inf;
  logic               better;

  // age is modular, so ordering survives a stamp wrap
  assign age    = now - stamp;
  assign better = !found || (ctl.inf && !best_inf) ||
                  ((ctl.inf == best_inf) && (age > best_age));

  always_ff @(posedge clk) begin
    if (rst) begin
      found <= 1'b0;
    end else if (ctl.clear) begin
      found <= 1'b0;
    end else if (ctl.en && better) begin
      found <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!ctl.clear && ctl.en && better) begin
      best_inf <= ctl.inf;
      best_age <= age;
      best_idx <= idx;
    end
  end

endmodule

`default_nettype wire

/* test/lrk_replacement_checker.sv */
// ----------------------------------------------------------------------------
// lrk_replacement_checker
// Watches the request, response and k-register ports of the LRU-K page
// replacer, tracks its frame pool in a shadow copy, and compares each
// response item field by field with the oldest predicted outcome.
// ----------------------------------------------------------------------------
module lrk_replacement_checker (
  input  logic                    clk,
  input  logic                    rst,
  lrk_req_if                      req,
  lrk_rsp_if                      rsp,
  input  logic                    cfg_we,
  input  logic [lrk_pkg::K_W-1:0] cfg_wdata,
  output int                      fail_count,
  output int                      open_count
);
  timeunit 1ns;
  timeprecision 1ps;
  import lrk_pkg::*;

  localparam int NF     = FRAMES_DEF;
  localparam int NK     = K_MAX_DEF;
  localparam int RING_N = 16;

  typedef struct packed {
    logic                  status;
    logic [FRAME_IO_W-1:0] victim;
    logic [COUNT_W-1:0]    count;
  } outcome_t;

  logic [STAMP_W-1:0] stamp_now;
  logic               tracked  [NF];
  logic               marked   [NF];
  logic [3:0]         hits     [NF];
  logic [2:0]         head     [NF];
  logic [STAMP_W-1:0] history  [NF][NK];
  logic [COUNT_W-1:0] marked_total;
  logic [K_W-1:0]     k_reg;

  outcome_t outcome_ring [RING_N];
  int       ring_rd;
  int       ring_wr;
  int       ring_fill;
  outcome_t want;
  outcome_t seen;
  int       errors;

  task automatic drop_frame(input int f);
    tracked[f] = 1'b0;
    marked[f]  = 1'b0;
    hits[f]    = '0;
    head[f]    = '0;
  endtask

  task automatic advance_pool(input action_t act, input logic [FRAME_IO_W-1:0] fr,
                              input logic fl, output outcome_t res);
    int k_eff;
    int n;
    int slot;
    int best;
    logic inf;
    logic best_inf;
    logic found;
    logic [STAMP_W-1:0] age;
    logic [STAMP_W-1:0] best_age;
    res = '0;
    res.status = 1'b1;
    found = 1'b0;
    best_inf = 1'b0;
    best_age = '0;
    best = 0;
    case (act)
      ACT_EVICT: begin
        if (k_reg == 0) k_eff = 1;
        else if (k_reg > NK) k_eff = NK;
        else k_eff = int'(k_reg);
        for (int f = 0; f < NF; f++) begin
          if (tracked[f] && marked[f]) begin
            inf = hits[f] < k_eff;
            n = inf ? int'(hits[f]) : k_eff;
            slot = (int'(head[f]) + NK - n) % NK;
            age = stamp_now - history[f][slot];
            if (!found || (inf && !best_inf) || (inf == best_inf && age > best_age)) begin
              found = 1'b1;
              best_inf = inf;
              best_age = age;
              best = f;
            end
          end
        end
        if (found) begin
          drop_frame(best);
          if (marked_total > 0) marked_total--;
          res.victim = best[FRAME_IO_W-1:0];
          res.status = 1'b0;
        end
      end
      ACT_RECORD: begin
        if (!tracked[fr]) begin
          drop_frame(int'(fr));
          tracked[fr] = 1'b1;
        end
        history[fr][head[fr]] = stamp_now;
        head[fr] = head[fr] + 3'd1;
        if (hits[fr] < NK) hits[fr]++;
        stamp_now++;
        res.status = 1'b0;
      end
      ACT_MARK: begin
        if (tracked[fr] && marked[fr] != fl) begin
          marked[fr] = fl;
          if (fl) marked_total++;
          else if (marked_total > 0) marked_total--;
          res.status = 1'b0;
        end
      end
      default: begin
        if (tracked[fr] && marked[fr]) begin
          drop_frame(int'(fr));
          if (marked_total > 0) marked_total--;
          res.status = 1'b0;
        end
      end
    endcase
    res.count = marked_total;
  endtask

  function automatic int field_ok(string name, int exp_v, logic [7:0] got_v);
    if (^got_v === 1'bx || got_v != exp_v) begin
      $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, exp_v, got_v);
      return 0;
    end
    return 1;
  endfunction

  always @(posedge clk) begin
    if (rst) begin
      errors = 0;
      stamp_now = '0;
      marked_total = '0;
      k_reg = K_RESET;
      for (int f = 0; f < NF; f++) drop_frame(f);
      ring_rd = 0;
      ring_wr = 0;
      ring_fill = 0;
    end else begin
      if (rsp.valid && rsp.ready) begin
        seen.status = rsp.status;
        seen.victim = rsp.victim_frame;
        seen.count  = rsp.evictable_count;
        if (ring_fill == 0) begin
          $display("%0t: unexpected item, expected none, actual status %0d victim %0d count %0d",
                   $time, seen.status, seen.victim, seen.count);
          errors++;
        end else begin
          want = outcome_ring[ring_rd];
          ring_rd = (ring_rd + 1) % RING_N;
          ring_fill--;
          if (!field_ok("status", int'(want.status), 8'(seen.status))) errors++;
          if (!field_ok("victim_frame", int'(want.victim), 8'(seen.victim))) errors++;
          if (!field_ok("evictable_count", int'(want.count), 8'(seen.count))) errors++;
        end
      end
      if (req.valid && req.ready) begin
        advance_pool(action_t'(req.action), req.frame, req.evictable_flag, want);
        if (ring_fill == RING_N) begin
          $display("%0t: too many open items, expected at most %0d, actual %0d",
                   $time, RING_N, ring_fill + 1);
          errors++;
        end else begin
          outcome_ring[ring_wr] = want;
          ring_wr = (ring_wr + 1) % RING_N;
          ring_fill++;
        end
      end
      if (cfg_we) k_reg = cfg_wdata;
    end
    fail_count <= errors;
    open_count <= ring_fill;
  end

endmodule

/* test/tb.sv */
// ----------------------------------------------------------------------------
// tb
// Drives the LRU-K page replacer with directed and random request items
// under several k settings, with random idle bursts on the request side
// and random stalls on the response side, and reports the verdict of the
// replacement checker.
// ----------------------------------------------------------------------------
module tb;
  timeunit 1ns;
  timeprecision 1ps;
  import lrk_pkg::*;

  localparam int PHASE_ITEMS = 280;

  logic           clk;
  logic           rst;
  logic           cfg_we;
  logic [K_W-1:0] cfg_wdata;
  int             fail_count;
  int             open_count;
  int             gap_pct;
  int             stall_pct;

  lrk_req_if req_ch ();
  lrk_rsp_if rsp_ch ();

  lru_k_page_replacer uut (
    .clk       (clk),
    .rst       (rst),
    .req       (req_ch),
    .rsp       (rsp_ch),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata)
  );

  lrk_replacement_checker chk (
    .clk        (clk),
    .rst        (rst),
    .req        (req_ch),
    .rsp        (rsp_ch),
    .cfg_we     (cfg_we),
    .cfg_wdata  (cfg_wdata),
    .fail_count (fail_count),
    .open_count (open_count)
  );

  always begin
    clk = 1'b0;
    #5;
    clk = 1'b1;
    #5;
  end

  task automatic send_item(input action_t a, input logic [FRAME_IO_W-1:0] f, input logic fl);
    if (gap_pct != 0 && $urandom_range(0, 99) < gap_pct) begin
      req_ch.valid <= 1'b0;
      repeat ($urandom_range(1, 15)) @(posedge clk);
    end
    req_ch.valid          <= 1'b1;
    req_ch.action         <= a;
    req_ch.frame          <= f;
    req_ch.evictable_flag <= fl;
    @(posedge clk);
    while (!req_ch.ready) @(posedge clk);
  endtask

  task automatic drain();
    req_ch.valid <= 1'b0;
    @(posedge clk);
    while (open_count != 0) @(posedge clk);
    repeat (24) @(posedge clk);
  endtask

  task automatic write_k(input logic [K_W-1:0] v);
    drain();
    cfg_we    <= 1'b1;
    cfg_wdata <= v;
    @(posedge clk);
    cfg_we    <= 1'b0;
  endtask

  task automatic random_item();
    int r;
    logic [FRAME_IO_W-1:0] f;
    r = $urandom_range(0, 99);
    f = $urandom_range(0, 1) ? FRAME_IO_W'($urandom_range(0, 3))
                             : FRAME_IO_W'($urandom_range(0, 15));
    if (r < 40) send_item(ACT_RECORD, f, 1'($urandom_range(0, 1)));
    else if (r < 70) send_item(ACT_MARK, f, $urandom_range(0, 99) < 70);
    else if (r < 80) send_item(ACT_REMOVE, f, 1'($urandom_range(0, 1)));
    else send_item(ACT_EVICT, FRAME_IO_W'($urandom_range(0, 15)), 1'($urandom_range(0, 1)));
  endtask

  initial begin
    rsp_ch.ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (stall_pct != 0 && $urandom_range(0, 99) < stall_pct) begin
        rsp_ch.ready <= 1'b0;
        repeat ($urandom_range(1, 15)) @(posedge clk);
      end
      rsp_ch.ready <= 1'b1;
    end
  end

  initial begin
    logic [K_W-1:0] k_plan [6];
    int pct_choice [3];
    k_plan = '{4'd1, 4'd8, 4'd0, 4'd15, 4'd3, 4'd2};
    pct_choice = '{0, 5, 25};
    gap_pct   = 0;
    stall_pct = 0;
    rst                   <= 1'b1;
    req_ch.valid          <= 1'b0;
    req_ch.action         <= ACT_RECORD;
    req_ch.frame          <= '0;
    req_ch.evictable_flag <= 1'b0;
    cfg_we                <= 1'b0;
    cfg_wdata             <= '0;
    repeat (6) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // directed part, k at its reset value
    send_item(ACT_EVICT, 4'd0, 1'b0);
    send_item(ACT_MARK, 4'd0, 1'b1);
    send_item(ACT_REMOVE, 4'd3, 1'b0);
    send_item(ACT_RECORD, 4'd0, 1'b0);
    send_item(ACT_RECORD, 4'd15, 1'b1);
    send_item(ACT_RECORD, 4'd5, 1'b0);
    send_item(ACT_MARK, 4'd0, 1'b0);
    send_item(ACT_MARK, 4'd0, 1'b1);
    send_item(ACT_MARK, 4'd0, 1'b1);
    send_item(ACT_REMOVE, 4'd15, 1'b0);
    send_item(ACT_MARK, 4'd15, 1'b1);
    send_item(ACT_REMOVE, 4'd15, 1'b1);
    send_item(ACT_RECORD, 4'd5, 1'b0);
    send_item(ACT_RECORD, 4'd10, 1'b0);
    send_item(ACT_RECORD, 4'd5, 1'b0);
    send_item(ACT_RECORD, 4'd10, 1'b0);
    send_item(ACT_MARK, 4'd5, 1'b1);
    send_item(ACT_MARK, 4'd10, 1'b1);
    send_item(ACT_EVICT, 4'd15, 1'b1);
    send_item(ACT_EVICT, 4'd0, 1'b0);
    send_item(ACT_EVICT, 4'd0, 1'b0);
    send_item(ACT_EVICT, 4'd0, 1'b0);
    send_item(ACT_RECORD, 4'd7, 1'b0);
    send_item(ACT_MARK, 4'd7, 1'b1);
    send_item(ACT_MARK, 4'd7, 1'b0);
    send_item(ACT_RECORD, 4'd15, 1'b0);

    for (int p = 0; p < 6; p++) begin
      write_k(k_plan[p]);
      if (p == 5) begin
        gap_pct   = 0;
        stall_pct = 0;
      end else begin
        gap_pct   = pct_choice[$urandom_range(0, 2)];
        stall_pct = pct_choice[$urandom_range(0, 2)];
      end
      for (int i = 0; i < PHASE_ITEMS; i++) random_item();
    end

    drain();
    if (fail_count == 0 && open_count == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

  initial begin
    #5_000_000;
    $display("tb: failure");
    $finish;
  end

endmodule
